// ===== src/sfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpa_pkg
// shared types and constants of the split fixed-point accumulator
// ----------------------------------------------------------------------------
package sfpa_pkg;

	localparam int unsigned MAG_W    = 96;  // magnitude of a truncated input
	localparam int unsigned MANT_W   = 53;  // aligned mantissa, hidden bit included
	localparam int unsigned EXP_W    = 12;  // signed power of two on the mantissa
	localparam int unsigned Q_DEPTH  = 4;
	localparam int unsigned Q_PTR_W  = 2;
	localparam int unsigned Q_CNT_W  = 3;

	localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
	localparam logic [7:0]  SGL_EXP_MAX = 8'hFF;
	localparam logic signed [EXP_W-1:0] DBL_BIAS = 12'sd1075;
	localparam logic signed [EXP_W-1:0] SGL_BIAS = 12'sd179;
	localparam logic signed [EXP_W-1:0] LSH_MAX  = 12'sd43;
	localparam logic signed [EXP_W-1:0] RSH_MAX  = 12'sd52;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ACCUM = 1'b1;

	// one classified item between the front and the back
	typedef struct packed {
		logic               func;
		logic               bad;
		logic signed [63:0] rem;
		logic signed [31:0] spill;
	} split_t;

endpackage

// ===== src/sfpa_front.sv =====
// ----------------------------------------------------------------------------
// sfpa_front
// unpacks the real value, truncates it and splits it at 2^S
// ----------------------------------------------------------------------------
module sfpa_front #(
	parameter int unsigned SPLIT_BITS_DOUBLE = 63,
	parameter int unsigned SPLIT_BITS_SINGLE = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                use_single,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [63:0]         value_bits,
	output logic                push,
	output sfpa_pkg::split_t    push_data,
	input  logic                q_full
);
	import sfpa_pkg::*;

	logic                     valid_s1;
	logic                     func_s1;
	logic                     sign_s1;
	logic                     bad_s1;
	logic [MAG_W-1:0]         mag_s1;

	logic                     sign_c;
	logic                     special_c;
	logic [MANT_W-1:0]        mant_c;
	logic signed [EXP_W-1:0]  k_c;
	logic signed [EXP_W-1:0]  rsh_c;
	logic [MAG_W-1:0]         mag_c;
	logic                     big_c;
	logic                     adv;

	logic [MAG_W-1:0]         spill_mag;
	logic [MAG_W-1:0]         rem_mask;
	logic [63:0]              rem_mag;
	logic                     range_ok;

	// unpack into mantissa * 2^k
	always_comb begin
		if (use_single) begin
			sign_c    = value_bits[31];
			special_c = (value_bits[30:23] == SGL_EXP_MAX);
			mant_c    = {(value_bits[30:23] != 8'd0), value_bits[22:0], 29'd0};
			k_c       = $signed({4'd0, value_bits[30:24],
				value_bits[23] | (value_bits[30:23] == 8'd0)}) - SGL_BIAS;
		end else begin
			sign_c    = value_bits[63];
			special_c = (value_bits[62:52] == DBL_EXP_MAX);
			mant_c    = {(value_bits[62:52] != 11'd0), value_bits[51:0]};
			k_c       = $signed({1'b0, value_bits[62:53],
				value_bits[52] | (value_bits[62:52] == 11'd0)}) - DBL_BIAS;
		end
		rsh_c = -k_c;
		big_c = (k_c > LSH_MAX);
		if (k_c >= 0)
			mag_c = {{(MAG_W-MANT_W){1'b0}}, mant_c} << k_c[5:0];
		else if (rsh_c > RSH_MAX)
			mag_c = '0;
		else
			mag_c = {{(MAG_W-MANT_W){1'b0}}, mant_c >> rsh_c[5:0]};
	end

	assign adv      = !valid_s1 || !q_full;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			func_s1 <= func;
			sign_s1 <= sign_c;
			bad_s1  <= special_c || big_c;
			mag_s1  <= mag_c;
		end
	end

	// split the truncated magnitude and range-check the spillover
	always_comb begin
		if (use_single) begin
			spill_mag = mag_s1 >> SPLIT_BITS_SINGLE;
			rem_mask  = (MAG_W'(1) << SPLIT_BITS_SINGLE) - MAG_W'(1);
		end else begin
			spill_mag = mag_s1 >> SPLIT_BITS_DOUBLE;
			rem_mask  = (MAG_W'(1) << SPLIT_BITS_DOUBLE) - MAG_W'(1);
		end
		rem_mag  = 64'(mag_s1 & rem_mask);
		range_ok = sign_s1 ? (spill_mag <= MAG_W'(64'h8000_0000))
		                   : (spill_mag <= MAG_W'(64'h7FFF_FFFF));
		push_data.func  = func_s1;
		push_data.bad   = bad_s1 || !range_ok;
		push_data.rem   = sign_s1 ? -$signed(rem_mag) : $signed(rem_mag);
		push_data.spill = sign_s1 ? -$signed(spill_mag[31:0]) : $signed(spill_mag[31:0]);
	end

	assign push = valid_s1 && !q_full;

endmodule

// ===== src/sfpa_fifo.sv =====
// ----------------------------------------------------------------------------
// sfpa_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module sfpa_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfpa_pkg::split_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output sfpa_pkg::split_t pop_data
);
	import sfpa_pkg::*;

	split_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== src/sfpa_back.sv =====
// ----------------------------------------------------------------------------
// sfpa_back
// applies load or accumulate to the state and holds the result beat
// ----------------------------------------------------------------------------
module sfpa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               use_single,
	input  logic               q_not_empty,
	input  sfpa_pkg::split_t   q_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] primary_sum,
	output logic signed [31:0] overflow_count,
	output logic               bad_input
);
	import sfpa_pkg::*;

	logic [63:0] primary_q;
	logic [31:0] overflow_q;
	logic        out_valid_q;
	logic        bad_q;

	logic [63:0] prim_n;
	logic [31:0] ovf_n;
	logic [31:0] o32, iv32, n32;
	logic [63:0] n64;
	logic        wrap;
	logic [31:0] adj;

	assign pop = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		o32  = primary_q[31:0];
		iv32 = q_data.rem[31:0];
		n32  = o32 + iv32;
		n64  = primary_q + q_data.rem;
		if (use_single)
			wrap = (o32[31] ^ n32[31]) && !(o32[31] ^ iv32[31]);
		else
			wrap = (primary_q[63] ^ n64[63]) && !(primary_q[63] ^ q_data.rem[63]);
		adj = use_single ? (iv32[31] ? 32'hFFFF_FFFE : 32'd2)
		                 : (q_data.rem[63] ? 32'hFFFF_FFFE : 32'd2);
		prim_n = primary_q;
		ovf_n  = overflow_q;
		if (!q_data.bad) begin
			if (q_data.func == FUNC_LOAD) begin
				ovf_n  = q_data.spill;
				prim_n = use_single ? {{32{iv32[31]}}, iv32} : q_data.rem;
			end else begin
				ovf_n  = overflow_q + q_data.spill + (wrap ? adj : 32'd0);
				prim_n = use_single ? {{32{n32[31]}}, n32} : n64;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q   <= '0;
			overflow_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				primary_q  <= prim_n;
				overflow_q <= ovf_n;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			bad_q <= q_data.bad;
	end

	assign out_valid      = out_valid_q;
	assign primary_sum    = $signed(primary_q);
	assign overflow_count = $signed(overflow_q);
	assign bad_input      = bad_q;

endmodule

// ===== src/split_fixed_point_accumulator.sv =====
// path: front stage register, a four-entry queue, then the back's result register
// throughput: one beat per cycle unless a stall holds it; the unpack and align
// shifter is one stage, the split and range check feed the queue, the back accumulates
// reset: accumulators, mode register and queue clear asynchronously
// ----------------------------------------------------------------------------
// split_fixed_point_accumulator
// truncates scaled reals into a split integer and loads or accumulates it
// ----------------------------------------------------------------------------
module split_fixed_point_accumulator #(
	parameter int unsigned SPLIT_BITS_DOUBLE = 63,
	parameter int unsigned SPLIT_BITS_SINGLE = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [63:0]        value_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] primary_sum,
	output logic signed [31:0] overflow_count,
	output logic               bad_input
);
	import sfpa_pkg::*;

	logic   use_single_q;
	logic   push, pop, q_full, q_not_empty;
	split_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_single_q <= 1'b0;
		end else if (cfg_we) begin
			use_single_q <= cfg_wdata;
		end
	end

	sfpa_front #(
		.SPLIT_BITS_DOUBLE(SPLIT_BITS_DOUBLE),
		.SPLIT_BITS_SINGLE(SPLIT_BITS_SINGLE)
	) u_front (
		.clk(clk), .arst_n(arst_n), .use_single(use_single_q),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.value_bits(value_bits), .push(push), .push_data(push_data),
		.q_full(q_full)
	);

	sfpa_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(q_full), .pop(pop), .not_empty(q_not_empty), .pop_data(pop_data)
	);

	sfpa_back u_back (
		.clk(clk), .arst_n(arst_n), .use_single(use_single_q),
		.q_not_empty(q_not_empty), .q_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .primary_sum(primary_sum),
		.overflow_count(overflow_count), .bad_input(bad_input)
	);

endmodule
